// ===== sv/mbrm_pkg.sv =====
// ----------------------------------------------------------------------------
// mbrm_pkg
// Shared types, protocol constants and the CRC-16 byte step for the Modbus
// RTU register master.
// ----------------------------------------------------------------------------
package mbrm_pkg;

  typedef enum logic [2:0] {
    FUNC_RD_CUR    = 3'd0,
    FUNC_RD_SET    = 3'd1,
    FUNC_RD_STATUS = 3'd2,
    FUNC_WR_RATE   = 3'd3,
    FUNC_RX_BYTE   = 3'd4,
    FUNC_TICK      = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    REQ_RD_CUR    = 2'd0,
    REQ_RD_SET    = 2'd1,
    REQ_RD_STATUS = 2'd2,
    REQ_WR_RATE   = 2'd3
  } req_e;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_BUSY = 1'b1
  } phase_e;

  typedef enum logic {
    CFG_READ_TIMEOUT  = 1'b0,
    CFG_WRITE_TIMEOUT = 1'b1
  } cfg_idx_e;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] TICK_MAX       = 16'hFFFF;
  localparam logic [15:0] RD_TIMEOUT_RST = 16'd40000;
  localparam logic [15:0] WR_TIMEOUT_RST = 16'd20000;

  localparam logic [7:0] MB_FC_READ   = 8'h03;
  localparam logic [7:0] MB_FC_WRITE  = 8'h10;
  localparam logic [7:0] MB_REG_CUR   = 8'h2E;
  localparam logic [7:0] MB_REG_SET   = 8'h30;
  localparam logic [7:0] MB_REG_STAT  = 8'h23;
  localparam logic [7:0] MB_CNT_ONE   = 8'h01;
  localparam logic [7:0] MB_CNT_TWO   = 8'h02;
  localparam logic [7:0] MB_WR_BYTES  = 8'h04;

  // frame lengths without CRC, expected response lengths
  localparam logic [3:0] FRM_LEN_RD   = 4'd6;
  localparam logic [3:0] FRM_LEN_WR   = 4'd11;
  localparam logic [3:0] RSP_LEN_RD2  = 4'd9;
  localparam logic [3:0] RSP_LEN_STAT = 4'd7;
  localparam logic [3:0] RSP_LEN_WR   = 4'd8;
  localparam logic [3:0] RSP_HDR_LEN  = 4'd6;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/modbus_rtu_register_master.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_register_master
// Modbus RTU master for single-slave register transactions with CRC-16.
// ----------------------------------------------------------------------------
// A start item (read current rate, read set rate, read status, write rate)
// builds a request frame and sends it out as one transmit word per cycle
// unless the output stalls: 8 words for a read, 13 for a write, CRC low byte
// then high byte last. The CRC is accumulated one byte per cycle as the frame
// drains through the output register, and the input is stalled until the last
// frame word has been loaded there. Received bytes and ticks are taken at one
// per cycle; the byte that completes a response, or the tick that reaches the
// timeout, produces one finished word, after which the next item is taken in
// the same cycle that word moves to the output register. A start item during
// a running transaction abandons it without a finished word. Timeouts are set
// through the APB registers (read timeout at 0x0, write timeout at 0x4).
module modbus_rtu_register_master (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [2:0]  func_i,
  input  logic        [7:0]  slave_addr_i,
  input  logic signed [31:0] write_value_i,
  input  logic        [7:0]  rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic        [7:0]  tx_byte_o,
  output logic               last_o,
  output logic               done_status_o,
  output logic        [31:0] read_value_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);
  import mbrm_pkg::*;

  // configuration
  logic [15:0] rd_timeout_q, wr_timeout_q;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;

  // transaction state
  phase_e      phase_q, phase_d;
  req_e        pend_q, pend_d;
  logic [7:0]  req_addr_q, req_addr_d;
  logic [3:0]  rx_cnt_q, rx_cnt_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [7:0]  rsp_q [8];
  logic [7:0]  rsp_now [8];
  logic        rsp_we;

  // request frame or result job handed to the emitter
  logic        job_load;
  logic        job_frame_d;
  logic        fin_status_d;
  logic [31:0] fin_value_d;

  logic        job_active_q;
  logic        job_frame_q;
  req_e        job_req_q;
  logic [7:0]  job_addr_q;
  logic [31:0] job_wval_q;
  logic [3:0]  job_idx_q;
  logic [15:0] job_crc_q;
  logic        fin_status_q;
  logic [31:0] fin_value_q;

  // output register
  logic        out_valid_q;
  logic        kind_q, last_q, status_q;
  logic [7:0]  tx_q;
  logic [31:0] value_q;

  logic        in_acc;
  logic [3:0]  exp_len;
  logic [15:0] limit;
  logic        wr_ok, rd_ok;

  logic        job_move, job_last, job_is_wr;
  logic [3:0]  frm_len;
  logic [7:0]  frm_byte, emit_byte;
  logic        emit_last;

  // --------------------------------------------------------------------------
  // APB registers
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_idx)
      CFG_READ_TIMEOUT:  prdata = {16'h0000, rd_timeout_q};
      CFG_WRITE_TIMEOUT: prdata = {16'h0000, wr_timeout_q};
      default:           prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_timeout_q <= RD_TIMEOUT_RST;
      wr_timeout_q <= WR_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_READ_TIMEOUT:  rd_timeout_q <= pwdata[15:0];
        CFG_WRITE_TIMEOUT: wr_timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Transaction control
  // --------------------------------------------------------------------------
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    case (pend_q)
      REQ_WR_RATE:   exp_len = RSP_LEN_WR;
      REQ_RD_STATUS: exp_len = RSP_LEN_STAT;
      default:       exp_len = RSP_LEN_RD2;
    endcase
  end

  assign limit = (pend_q == REQ_WR_RATE) ? wr_timeout_q : rd_timeout_q;

  // response bytes as they stand once the incoming byte is in place
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rsp_now[i] = (rx_cnt_q == 4'(i)) ? rx_byte_i : rsp_q[i];
    end
  end

  assign wr_ok = (rsp_now[0] == req_addr_q) && (rsp_now[1] == MB_FC_WRITE) &&
                 (rsp_now[2] == 8'h00) && (rsp_now[3] == MB_REG_SET) &&
                 (rsp_now[4] == 8'h00) && (rsp_now[5] == MB_CNT_TWO) &&
                 (rsp_now[6] == rx_crc_q[7:0]) && (rsp_now[7] == rx_crc_q[15:8]);
  assign rd_ok = (rsp_now[1] == MB_FC_READ);

  always_comb begin
    phase_d      = phase_q;
    pend_d       = pend_q;
    req_addr_d   = req_addr_q;
    rx_cnt_d     = rx_cnt_q;
    tick_d       = tick_q;
    rx_crc_d     = rx_crc_q;
    rsp_we       = 1'b0;
    job_load     = 1'b0;
    job_frame_d  = 1'b0;
    fin_status_d = 1'b0;
    fin_value_d  = 32'h0000_0000;

    if (in_acc) begin
      case (func_e'(func_i))
        FUNC_RD_CUR, FUNC_RD_SET, FUNC_RD_STATUS, FUNC_WR_RATE: begin
          phase_d     = PH_BUSY;
          pend_d      = req_e'(func_i[1:0]);
          req_addr_d  = slave_addr_i;
          rx_cnt_d    = 4'd0;
          tick_d      = 16'h0000;
          rx_crc_d    = CRC_INIT;
          job_load    = 1'b1;
          job_frame_d = 1'b1;
        end
        FUNC_RX_BYTE: begin
          if (phase_q == PH_BUSY) begin
            rx_cnt_d = rx_cnt_q + 4'd1;
            rsp_we   = !rx_cnt_q[3];
            if (rx_cnt_q < RSP_HDR_LEN) begin
              rx_crc_d = crc_feed(rx_crc_q, rx_byte_i);
            end
            if (rx_cnt_d >= exp_len) begin
              phase_d  = PH_IDLE;
              job_load = 1'b1;
              if (pend_q == REQ_WR_RATE) begin
                fin_status_d = !wr_ok;
              end else if (!rd_ok) begin
                fin_status_d = 1'b1;
              end else if (pend_q == REQ_RD_STATUS) begin
                fin_value_d = {16'h0000, rsp_now[3], rsp_now[4]};
              end else begin
                fin_value_d = {rsp_now[3], rsp_now[4], rsp_now[5], rsp_now[6]};
              end
            end
          end
        end
        FUNC_TICK: begin
          if (phase_q == PH_BUSY) begin
            tick_d = (tick_q != TICK_MAX) ? tick_q + 16'd1 : tick_q;
            if (tick_d >= limit) begin
              phase_d      = PH_IDLE;
              job_load     = 1'b1;
              fin_status_d = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      pend_q     <= REQ_RD_CUR;
      req_addr_q <= 8'h00;
      rx_cnt_q   <= 4'd0;
      tick_q     <= 16'h0000;
      rx_crc_q   <= CRC_INIT;
    end else begin
      phase_q    <= phase_d;
      pend_q     <= pend_d;
      req_addr_q <= req_addr_d;
      rx_cnt_q   <= rx_cnt_d;
      tick_q     <= tick_d;
      rx_crc_q   <= rx_crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_we) begin
      rsp_q[rx_cnt_q[2:0]] <= rx_byte_i;
    end
  end

  // --------------------------------------------------------------------------
  // Emitter: drain the current job into the output register
  // --------------------------------------------------------------------------
  assign job_is_wr = (job_req_q == REQ_WR_RATE);
  assign frm_len   = job_is_wr ? FRM_LEN_WR : FRM_LEN_RD;

  always_comb begin
    case (job_idx_q)
      4'd0:    frm_byte = job_addr_q;
      4'd1:    frm_byte = job_is_wr ? MB_FC_WRITE : MB_FC_READ;
      4'd3: begin
        case (job_req_q)
          REQ_RD_CUR:    frm_byte = MB_REG_CUR;
          REQ_RD_STATUS: frm_byte = MB_REG_STAT;
          default:       frm_byte = MB_REG_SET;
        endcase
      end
      4'd5:    frm_byte = (job_req_q == REQ_RD_STATUS) ? MB_CNT_ONE : MB_CNT_TWO;
      4'd6:    frm_byte = MB_WR_BYTES;
      4'd7:    frm_byte = job_wval_q[31:24];
      4'd8:    frm_byte = job_wval_q[23:16];
      4'd9:    frm_byte = job_wval_q[15:8];
      4'd10:   frm_byte = job_wval_q[7:0];
      default: frm_byte = 8'h00;
    endcase
  end

  always_comb begin
    emit_last = 1'b0;
    if (job_idx_q < frm_len) begin
      emit_byte = frm_byte;
    end else if (job_idx_q == frm_len) begin
      emit_byte = job_crc_q[7:0];
    end else begin
      emit_byte = job_crc_q[15:8];
      emit_last = 1'b1;
    end
  end

  assign job_move   = job_active_q && (!out_valid_q || !out_stall_i);
  assign job_last   = !job_frame_q || emit_last;
  assign in_stall_o = job_active_q && !(job_move && job_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_active_q <= 1'b0;
      job_frame_q  <= 1'b0;
      job_idx_q    <= 4'd0;
      job_crc_q    <= CRC_INIT;
    end else if (job_load) begin
      job_active_q <= 1'b1;
      job_frame_q  <= job_frame_d;
      job_idx_q    <= 4'd0;
      job_crc_q    <= CRC_INIT;
    end else if (job_move) begin
      job_idx_q <= job_idx_q + 4'd1;
      if (job_frame_q && (job_idx_q < frm_len)) begin
        job_crc_q <= crc_feed(job_crc_q, frm_byte);
      end
      if (job_last) begin
        job_active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_req_q    <= req_e'(func_i[1:0]);
      job_addr_q   <= slave_addr_i;
      job_wval_q   <= write_value_i;
      fin_status_q <= fin_status_d;
      fin_value_q  <= fin_value_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_move) begin
      kind_q   <= !job_frame_q;
      tx_q     <= job_frame_q ? emit_byte : 8'h00;
      last_q   <= job_frame_q && emit_last;
      status_q <= !job_frame_q && fin_status_q;
      value_q  <= job_frame_q ? 32'h0000_0000 : fin_value_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign tx_byte_o     = tx_q;
  assign last_o        = last_q;
  assign done_status_o = status_q;
  assign read_value_o  = value_q;

endmodule
